FILE: rtl/cst_pkg.sv
// Shared types and constants for the shell command tokenizer.
package cst_pkg;

  // Result kinds
  localparam logic [1:0] KIND_BYTE      = 2'd0;
  localparam logic [1:0] KIND_TOKEN_END = 2'd1;
  localparam logic [1:0] KIND_CMD_END   = 2'd2;

  // Bit positions within the flag nibble
  localparam int FLAG_CHAIN = 0;
  localparam int FLAG_PIPE  = 1;
  localparam int FLAG_SUB   = 2;
  localparam int FLAG_REDIR = 3;

  // Characters of interest
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_LT      = 8'h3c;
  localparam logic [7:0] CH_GT      = 8'h3e;
  localparam logic [7:0] CH_CARET   = 8'h5e;
  localparam logic [7:0] CH_BAR     = 8'h7c;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_ASCII_MAX = 8'h7f;

  // Slots a single item can produce
  localparam int MAX_RES = 3;

  typedef struct packed {
    logic       in_quote;
    logic       quotes_seen;
    logic       token_nonempty;
    logic       bar_pending;
    logic       skip_next;
    logic [3:0] flags;
  } tok_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] token_byte;
    logic [3:0] flags;
    logic       last;
  } result_t;

endpackage

FILE: rtl/cst_step.sv
// Per-byte tokenizer rules: next state and the ordered result slots.
module cst_step (
  input  cst_pkg::tok_state_t st,
  input  logic [7:0]          ch,
  input  logic                has_char,
  input  logic                end_of_command,
  output cst_pkg::tok_state_t st_nxt,
  output cst_pkg::result_t    res [cst_pkg::MAX_RES],
  output logic [1:0]          res_cnt
);
  import cst_pkg::*;

  logic       done;
  logic       bv;
  result_t    b_res;
  result_t    te_res;
  result_t    cmd_res;
  logic       is_ws;
  logic       is_meta;
  tok_state_t s;
  logic [1:0] cnt;

  assign is_ws   = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
  assign is_meta = (ch == CH_AMP) || (ch == CH_BAR) || (ch == CH_LT) ||
                   (ch == CH_GT) || (ch == CH_CARET) || (ch == CH_PERCENT);

  always_comb begin
    s      = st;
    done   = 1'b0;
    bv     = 1'b0;
    b_res  = '0;
    b_res.kind = KIND_BYTE;
    te_res = '0;
    te_res.kind = KIND_TOKEN_END;
    cmd_res = '0;
    cmd_res.kind = KIND_CMD_END;

    if (has_char) begin
      // '|' decided on the byte after it
      if (st.bar_pending) begin
        s.bar_pending = 1'b0;
        if (ch == CH_BAR) begin
          s.flags[FLAG_CHAIN] = 1'b1;
          done = 1'b1;
        end else begin
          s.flags[FLAG_PIPE] = 1'b1;
        end
      end
      if (!done && st.skip_next) begin
        s.skip_next = 1'b0;
        done = 1'b1;
      end
      if (!done) begin
        if (ch > CH_ASCII_MAX) begin
          s.flags[FLAG_CHAIN] = 1'b1;
        end
        priority if (ch == CH_QUOTE) begin
          s.in_quote    = !st.in_quote;
          s.quotes_seen = 1'b1;
        end else if (st.in_quote) begin
          if (ch == CH_PERCENT) begin
            s.flags[FLAG_SUB] = 1'b1;
          end
          s.token_nonempty = 1'b1;
          bv = 1'b1;
          b_res.token_byte = ch;
        end else if (is_ws) begin
          if (st.token_nonempty || st.quotes_seen) begin
            bv = 1'b1;
            b_res.kind = KIND_TOKEN_END;
          end
          s.token_nonempty = 1'b0;
          s.quotes_seen    = 1'b0;
        end else if (is_meta) begin
          priority if (ch == CH_AMP || ch == CH_CARET) begin
            s.flags[FLAG_CHAIN] = 1'b1;
          end else if (ch == CH_BAR) begin
            s.bar_pending = 1'b1;
          end else if (ch == CH_LT || ch == CH_GT) begin
            s.flags[FLAG_REDIR] = 1'b1;
          end else begin
            s.flags[FLAG_SUB] = 1'b1;
          end
          if (ch == CH_CARET) begin
            s.skip_next = 1'b1;
          end
          if (st.token_nonempty) begin
            bv = 1'b1;
            b_res.kind = KIND_TOKEN_END;
          end
          s.token_nonempty = 1'b0;
        end else begin
          s.token_nonempty = 1'b1;
          bv = 1'b1;
          b_res.token_byte = ch;
        end
      end
    end

    // End of command: close out and return to reset
    if (end_of_command) begin
      if (s.bar_pending) s.flags[FLAG_PIPE]  = 1'b1;
      if (s.in_quote)    s.flags[FLAG_CHAIN] = 1'b1;
      cmd_res.flags = s.flags;
    end

    // Pack results in order
    res[0] = '0;
    res[1] = '0;
    res[2] = '0;
    cnt    = 2'd0;
    if (bv) begin
      res[cnt] = b_res;
      cnt = cnt + 2'd1;
    end
    if (end_of_command && (s.token_nonempty || s.quotes_seen)) begin
      res[cnt] = te_res;
      cnt = cnt + 2'd1;
    end
    if (end_of_command) begin
      res[cnt] = cmd_res;
      cnt = cnt + 2'd1;
    end
    if (cnt != 2'd0) begin
      res[cnt - 2'd1].last = 1'b1;
    end

    if (end_of_command) begin
      s = '0;
    end
    st_nxt  = s;
    res_cnt = cnt;
  end

endmodule

FILE: rtl/cst_outq.sv
// Four-entry result queue taking up to three results per cycle.
module cst_outq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            push_cnt,
  input  cst_pkg::result_t      push_res [cst_pkg::MAX_RES],
  output logic                  room,
  input  logic                  pop,
  output logic                  head_valid,
  output cst_pkg::result_t      head
);
  import cst_pkg::*;

  result_t    mem_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       do_pop;

  assign head_valid = (count_r != 3'd0);
  assign head       = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;
  // Three free slots needed before taking an item
  assign room       = (count_r <= 3'd1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push_cnt;
    rd_ptr_nxt = rd_ptr_r + {1'b0, do_pop};
    count_nxt  = count_r + {1'b0, push_cnt} - {2'b00, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < push_cnt) begin
        mem_r[wr_ptr_r + 2'(i)] <= push_res[i];
      end
    end
  end

endmodule

FILE: rtl/cmd_shell_command_tokenizer.sv
// Top level of the shell command tokenizer.
//
// Usage:
//   in_*  : one command-line byte per item. in_tdata = ch, in_tuser = has_char
//           (0 for a bare end marker), in_tlast = end of command.
//   out_* : result items. out_tuser = kind (byte, token end, command end),
//           out_tdata = token byte and the four flags, out_tlast marks the
//           last result caused by an input item.
// Results of an item are written into the result queue as it is accepted; the
// first can reach the output in the cycle after. Throughput: one item per cycle
//   while each item gives at most one result and the receiver keeps up; the
//   output side moves one result per cycle, so an end-of-command item (up to
//   three results) holds the input back while the queue drains. Bound set by
//   the four-entry result queue, which takes an item only with three free slots.
// Reset (rst_n low, synchronous): tokenizer state and flags clear, the
//   queue empties.
// Stall: with out_tready low results stay in the queue; in_tready drops once
//   fewer than three slots are free. Nothing is lost or repeated.
// Idle items (no byte, not end of command) are accepted and give no result.
module cmd_shell_command_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic [0:0]  in_tuser,   // [0] has_char
  input  logic        in_tlast,   // end_of_command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] token_byte, [8] chain, [9] pipe,
                                  // [10] subshell, [11] redirect, [15:12] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last_of_run
);
  import cst_pkg::*;

  tok_state_t st_r, st_nxt, st_step;
  result_t    res [MAX_RES];
  logic [1:0] res_cnt;
  logic       room;
  logic       in_fire;
  logic       head_valid;
  result_t    head;

  assign in_tready = room;
  assign in_fire   = in_tvalid && room;

  cst_step u_step (
    .st             (st_r),
    .ch             (in_tdata),
    .has_char       (in_tuser[0]),
    .end_of_command (in_tlast),
    .st_nxt         (st_step),
    .res            (res),
    .res_cnt        (res_cnt)
  );

  assign st_nxt = in_fire ? st_step : st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  cst_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (in_fire ? res_cnt : 2'd0),
    .push_res   (res),
    .room       (room),
    .pop        (out_tready),
    .head_valid (head_valid),
    .head       (head)
  );

  assign out_tvalid = head_valid;
  assign out_tdata  = {4'b0000, head.flags, head.token_byte};
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the shell command tokenizer: directed and random command lines.
import cst_pkg::*;

// Tracks tokenizer state and the results it owes, then checks what comes out.
class token_scoreboard;
  bit             in_quote;
  bit             quotes_seen;
  bit             token_nonempty;
  bit             bar_pending;
  bit             skip_next;
  logic [3:0]     seen_flags;
  result_t        pending_results[$];
  int             errors;

  function new();
    clear_state();
    errors = 0;
  endfunction

  function void clear_state();
    in_quote       = 1'b0;
    quotes_seen    = 1'b0;
    token_nonempty = 1'b0;
    bar_pending    = 1'b0;
    skip_next      = 1'b0;
    seen_flags     = 4'h0;
  endfunction

  function void emit(ref result_t run[$], input logic [1:0] kind,
                     input logic [7:0] token_byte, input logic [3:0] flags);
    result_t r;
    r.kind       = kind;
    r.token_byte = token_byte;
    r.flags      = flags;
    r.last       = 1'b0;
    run.push_back(r);
  endfunction

  // One command byte through the quoting / operator rules.
  function void absorb_byte(ref result_t run[$], input logic [7:0] c);
    if (bar_pending) begin
      bar_pending = 1'b0;
      if (c == CH_BAR) begin
        seen_flags[FLAG_CHAIN] = 1'b1;
        return;
      end
      seen_flags[FLAG_PIPE] = 1'b1;
    end
    if (skip_next) begin
      skip_next = 1'b0;
      return;
    end
    if (c > CH_ASCII_MAX) seen_flags[FLAG_CHAIN] = 1'b1;
    if (c == CH_QUOTE) begin
      in_quote    = !in_quote;
      quotes_seen = 1'b1;
      return;
    end
    if (in_quote) begin
      if (c == CH_PERCENT) seen_flags[FLAG_SUB] = 1'b1;
      token_nonempty = 1'b1;
      emit(run, KIND_BYTE, c, 4'h0);
      return;
    end
    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
      if (token_nonempty || quotes_seen) begin
        emit(run, KIND_TOKEN_END, 8'h00, 4'h0);
        token_nonempty = 1'b0;
        quotes_seen    = 1'b0;
      end
      return;
    end
    if (c == CH_AMP || c == CH_BAR || c == CH_LT || c == CH_GT ||
        c == CH_CARET || c == CH_PERCENT) begin
      case (c)
        CH_AMP, CH_CARET: seen_flags[FLAG_CHAIN] = 1'b1;
        CH_BAR:           bar_pending = 1'b1;
        CH_LT, CH_GT:     seen_flags[FLAG_REDIR] = 1'b1;
        default:          seen_flags[FLAG_SUB] = 1'b1;
      endcase
      if (c == CH_CARET) skip_next = 1'b1;
      if (token_nonempty) begin
        emit(run, KIND_TOKEN_END, 8'h00, 4'h0);
        token_nonempty = 1'b0;
      end
      return;
    end
    token_nonempty = 1'b1;
    emit(run, KIND_BYTE, c, 4'h0);
  endfunction

  // Accepted input item: queue up every result it causes.
  function void note_input(logic [7:0] ch, logic has_char, logic end_cmd);
    result_t run[$];
    if (has_char) absorb_byte(run, ch);
    if (end_cmd) begin
      if (bar_pending) seen_flags[FLAG_PIPE] = 1'b1;
      if (in_quote) seen_flags[FLAG_CHAIN] = 1'b1;
      if (token_nonempty || quotes_seen) emit(run, KIND_TOKEN_END, 8'h00, 4'h0);
      emit(run, KIND_CMD_END, 8'h00, seen_flags);
      clear_state();
    end
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) pending_results.push_back(run[i]);
  endfunction

  function void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_result(logic [1:0] kind, logic [15:0] data, logic last);
    result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual kind %h data %h last %b",
               $time, kind, data, last);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    check_field("kind", 8'(want.kind), 8'(kind));
    check_field("token_byte", want.token_byte, data[7:0]);
    check_field("chain", 8'(want.flags[FLAG_CHAIN]), 8'(data[8 + FLAG_CHAIN]));
    check_field("pipe", 8'(want.flags[FLAG_PIPE]), 8'(data[8 + FLAG_PIPE]));
    check_field("subshell", 8'(want.flags[FLAG_SUB]), 8'(data[8 + FLAG_SUB]));
    check_field("redirect", 8'(want.flags[FLAG_REDIR]), 8'(data[8 + FLAG_REDIR]));
    check_field("pad", 8'h00, 8'(data[15:12]));
    check_field("last", 8'(want.last), 8'(last));
  endfunction

  function int outstanding();
    return pending_results.size();
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT  = 200000;  // far beyond the slowest legal run
  localparam int DRAIN_CYCLES = 8;       // idle time after the last result is checked

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;  // [7:0] ch
  logic [0:0]  in_tuser   = 1'b0;   // [0] has_char
  logic        in_tlast   = 1'b0;   // end_of_command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;           // [7:0] token_byte, [8] chain, [9] pipe,
                                    // [10] subshell, [11] redirect, [15:12] zero
  logic [1:0]  out_tuser;           // [1:0] kind
  logic        out_tlast;           // last_of_run

  int              snd_idle_pct = 0;
  int              rcv_idle_pct = 0;
  int              cycle_count  = 0;
  token_scoreboard sb;

  // Bytes with a meaning to the tokenizer, used to bias random commands
  logic [7:0] special_set [7] = '{CH_QUOTE, CH_PERCENT, CH_AMP, CH_LT,
                                  CH_GT, CH_CARET, CH_BAR};

  cmd_shell_command_tokenizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: check every accepted item, then pick next cycle's ready.
  // Values read here are the ones present at the edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, out_tdata, out_tlast);
    out_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // Present one item, with random idle cycles ahead of it, and hold it until
  // taken. tvalid stays high between back-to-back items.
  task automatic send_item(input logic [7:0] ch, input logic has_char,
                           input logic end_cmd);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tuser  <= has_char;
    in_tlast  <= end_cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(ch, has_char, end_cmd);
  endtask

  // Mostly plain word characters, with whitespace, quotes and operators
  // frequent enough to exercise every rule; the wide class covers high bytes.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0, 1: return special_set[$urandom_range(0, 6)];
      2:    return ($urandom_range(0, 1) != 0) ? CH_SPACE : 8'($urandom_range(9, 13));
      3:    return CH_QUOTE;
      4:    return CH_BAR;
      5:    return 8'($urandom_range(0, 255));
      6:    return 8'($urandom_range(128, 255));
      default: begin
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(48, 57));
        return 8'($urandom_range(97, 122));
      end
    endcase
  endfunction

  // Random command lines, each closed either on its last byte or by a bare
  // end marker. Stray idle items are mixed in but not counted.
  task automatic send_random_commands(input int n_items);
    int sent;
    int len;
    bit bare_end;
    sent = 0;
    while (sent < n_items) begin
      len      = $urandom_range(0, 12);
      bare_end = (len == 0) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0)
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_item(pick_byte(), 1'b1, !bare_end && (i == len - 1));
        sent++;
      end
      if (bare_end) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        sent++;
      end
    end
  endtask

  task automatic run_directed();
    // empty quotes still make a token; whitespace closes it; bare end marker
    send_item(CH_QUOTE, 1'b1, 1'b0);
    send_item(CH_QUOTE, 1'b1, 1'b0);
    send_item(CH_SPACE, 1'b1, 1'b0);
    send_item("a", 1'b1, 1'b0);
    send_item("b", 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    // lone bar is a pipe (decided on the next byte); top byte value sets chain
    send_item("a", 1'b1, 1'b0);
    send_item(CH_BAR, 1'b1, 1'b0);
    send_item("b", 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);
    // double bar is a chain; caret swallows a quote; caret as last byte
    send_item(CH_BAR, 1'b1, 1'b0);
    send_item(CH_BAR, 1'b1, 1'b0);
    send_item(CH_CARET, 1'b1, 1'b0);
    send_item(CH_QUOTE, 1'b1, 1'b0);
    send_item(CH_CARET, 1'b1, 1'b1);
    // unclosed quote holding a percent and a zero byte
    send_item(CH_QUOTE, 1'b1, 1'b0);
    send_item(CH_PERCENT, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    // idle item, then every other operator, VT, lowest high byte, and a bar
    // still pending when the command ends
    send_item(8'h5a, 1'b0, 1'b0);
    send_item("x", 1'b1, 1'b0);
    send_item(CH_AMP, 1'b1, 1'b0);
    send_item(CH_PERCENT, 1'b1, 1'b0);
    send_item(CH_GT, 1'b1, 1'b0);
    send_item(CH_LT, 1'b1, 1'b0);
    send_item(8'h0b, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(CH_BAR, 1'b1, 1'b1);
    // empty command
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // sender idles lightly, receiver heavily
    snd_idle_pct = 27;
    rcv_idle_pct = 53;
    run_directed();
    send_random_commands(70);

    // roles swapped
    snd_idle_pct = 53;
    rcv_idle_pct = 27;
    send_random_commands(70);

    // full rate both sides
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    send_random_commands(62);
    in_tvalid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/cst_pkg.sv
rtl/cst_step.sv
rtl/cst_outq.sv
rtl/cmd_shell_command_tokenizer.sv
verif/tb.sv
